>>> design/enc_spd_pkg.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Widths, arithmetic constants, register indexes and the sequencer states
// shared by the encoder speed estimator.
// ----------------------------------------------------------------------------
package enc_spd_pkg;

	// Default number of fraction bits of every speed value.
	localparam int FRAC_BITS_DEF = 8;

	// Field and register widths.
	localparam int TICK_W     = 32;
	localparam int TIME_W     = 32;
	localparam int SPEED_W    = 32;
	localparam int DEADBAND_W = 24;
	localparam int WEIGHT_W   = 17;
	localparam int PPR_W      = 16;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	// Shared shift-add multiplier: a 64-bit accumulator and a multiplier
	// register wide enough for the widest constant operand.
	localparam int ACC_W = 64;
	localparam int MUL_W = 21;

	// Divisor is time delta times pulses per revolution.
	localparam int DEN_W = TIME_W + PPR_W;
	// Tick magnitude (up to 2^31) times the rpm factor stays below 2^45.
	localparam int PROD_W = 45;

	// 0.25 * 1000 * 60 for quadrature counting in milliseconds.
	localparam logic [13:0] RPM_FACTOR = 14'd15000;
	// About 2*3.14/60 in units of 2^-24.
	localparam logic [20:0] RAD_COEF  = 21'd1756015;
	localparam int          RAD_SHIFT = 24;
	// Average weight of one in Q1.16.
	localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
	localparam int          WEIGHT_SHIFT = 16;

	// Register reset values.
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST = '0;
	localparam logic [WEIGHT_W-1:0]   WEIGHT_RST   = 17'd6554;
	localparam logic [PPR_W-1:0]      PPR_RST      = 16'd1;

	// Register indexes, one 32-bit word each.
	typedef enum logic [1:0] {
		REG_DEADBAND,
		REG_WEIGHT,
		REG_PPR,
		REG_RADIANS
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEN_MUL,
		ST_NUM_MUL,
		ST_DIVIDE,
		ST_SATURATE,
		ST_AVG_MUL,
		ST_RAD_MUL,
		ST_DONE
	} state_t;

endpackage

>>> design/encoder_speed_estimator.sv
// ----------------------------------------------------------------------------
// Encoder speed estimator
// Computes instantaneous rpm from tick and millisecond stamps, blends it into
// an exponential average, applies a deadband and optionally scales to rad/s.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// config    in         psel/penable/pready paddr, pwdata, pwrite, prdata
// sample    in         in_valid/in_stall   tick_count, time_ms
// result    out        out_valid/out_stall speed, instant_rpm
//
// One request at a time runs through a shared shift-add multiplier (one
// multiplier bit per cycle) and a radix-2 divider (one quotient bit per cycle).
// A request whose time stamp repeats the stored one is taken with no result.
// Reset clears the stored ticks, time and average and loads register defaults.
// A finished result waits in the output register while out_stall is high;
// the next request is taken meanwhile and holds in its last cycle if needed.
module encoder_speed_estimator #(
	parameter int FRAC_BITS = enc_spd_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [enc_spd_pkg::APB_AW-1:0]        paddr,
	input  logic [enc_spd_pkg::APB_DW-1:0]        pwdata,
	output logic [enc_spd_pkg::APB_DW-1:0]        prdata,
	output logic                                  pready,
	// Sample channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [enc_spd_pkg::TICK_W-1:0] tick_count,
	input  logic [enc_spd_pkg::TIME_W-1:0]        time_ms,
	// Result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [enc_spd_pkg::SPEED_W-1:0] speed,
	output logic signed [enc_spd_pkg::SPEED_W-1:0] instant_rpm
);
	import enc_spd_pkg::*;

	localparam int NUM_W = PROD_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int REM_W = DEN_W + 1;

	// Configuration registers
	logic [DEADBAND_W-1:0] deadband_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [PPR_W-1:0]      ppr_q;
	logic                  radians_q;

	// Speed state
	logic [TICK_W-1:0]         last_ticks_q;
	logic [TIME_W-1:0]         last_time_q;
	logic signed [SPEED_W-1:0] last_avg_q;

	// Sequencer
	state_t state_q;
	state_t state_d;
	logic   out_load;

	// Datapath registers
	logic                      neg_q;
	logic [TICK_W-1:0]         mag_q;
	logic [ACC_W-1:0]          acc_q;
	logic [ACC_W-1:0]          mcand_q;
	logic [MUL_W-1:0]          mult_q;
	logic [DEN_W-1:0]          den_q;
	logic [NUM_W-1:0]          num_q;
	logic [REM_W-1:0]          rem_q;
	logic [SPEED_W-1:0]        quo_q;
	logic                      ovf_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SPEED_W-1:0] inst_q;
	logic signed [SPEED_W-1:0] spd_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [SPEED_W-1:0] instant_q;
	logic                      out_valid_q;

	// Combinational helpers
	logic                      in_accept;
	logic                      new_sample;
	logic [TIME_W-1:0]         dt_w;
	logic [TICK_W-1:0]         dn_w;
	logic [PPR_W-1:0]          ppr_eff;
	logic [WEIGHT_W-1:0]       w_eff;
	logic                      mul_done;
	logic [REM_W-1:0]          trial;
	logic                      trial_ge;
	logic signed [SPEED_W-1:0] inst_w;
	logic [SPEED_W:0]          diff_w;
	logic signed [SPEED_W-1:0] avg_raw;
	logic [SPEED_W-1:0]        avg_abs;
	logic signed [SPEED_W-1:0] avg_db;
	logic                      cfg_write;
	reg_idx_t                  cfg_idx;

	// Configuration access
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_DEADBAND: prdata = APB_DW'(deadband_q);
			REG_WEIGHT:   prdata = APB_DW'(weight_q);
			REG_PPR:      prdata = APB_DW'(ppr_q);
			REG_RADIANS:  prdata = APB_DW'(radians_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			weight_q   <= WEIGHT_RST;
			ppr_q      <= PPR_RST;
			radians_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_DEADBAND: deadband_q <= pwdata[DEADBAND_W-1:0];
				REG_WEIGHT:   weight_q   <= pwdata[WEIGHT_W-1:0];
				REG_PPR:      ppr_q      <= pwdata[PPR_W-1:0];
				REG_RADIANS:  radians_q  <= pwdata[0];
				default:      ;
			endcase
		end
	end

	// Input request and wrapping deltas
	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign dt_w       = time_ms - last_time_q;
	assign dn_w       = tick_count - last_ticks_q;
	assign new_sample = in_accept && (dt_w != '0);

	// Register values of zero and out-of-range weights are clamped.
	assign ppr_eff = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

	always_comb begin
		if (weight_q == '0) begin
			w_eff = WEIGHT_W'(1);
		end else if (weight_q > WEIGHT_ONE) begin
			w_eff = WEIGHT_ONE;
		end else begin
			w_eff = weight_q;
		end
	end

	// Multiplier finishes once all multiplier bits have been consumed.
	assign mul_done = (mult_q == '0);

	// One restoring divide step: bring down the next numerator bit.
	assign trial    = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	// Saturate the quotient to the signed range and apply the sign.
	always_comb begin
		if (ovf_q || quo_q[SPEED_W-1]) begin
			inst_w = neg_q ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
		end else begin
			inst_w = neg_q ? -$signed(quo_q) : $signed(quo_q);
		end
	end

	// Average as last + (inst - last) * w, then floor by 2^16.
	assign diff_w  = {inst_w[SPEED_W-1], inst_w} - {last_avg_q[SPEED_W-1], last_avg_q};
	assign avg_raw = $signed(acc_q[WEIGHT_SHIFT+SPEED_W-1:WEIGHT_SHIFT]);
	assign avg_abs = avg_raw[SPEED_W-1] ? SPEED_W'(-avg_raw) : SPEED_W'(avg_raw);
	assign avg_db  = (avg_abs < SPEED_W'(deadband_q)) ? '0 : avg_raw;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and output load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (new_sample) begin
					state_d = ST_DEN_MUL;
				end
			end
			ST_DEN_MUL: begin
				if (mul_done) begin
					state_d = ST_NUM_MUL;
				end
			end
			ST_NUM_MUL: begin
				if (mul_done) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (cnt_q == '0) begin
					state_d = ST_SATURATE;
				end
			end
			ST_SATURATE: begin
				state_d = ST_AVG_MUL;
			end
			ST_AVG_MUL: begin
				if (mul_done) begin
					state_d = radians_q ? ST_RAD_MUL : ST_DONE;
				end
			end
			ST_RAD_MUL: begin
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Stored speed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ticks_q <= '0;
			last_time_q  <= '0;
			last_avg_q   <= '0;
		end else begin
			if (new_sample) begin
				last_ticks_q <= tick_count;
				last_time_q  <= time_ms;
			end
			if (state_q == ST_AVG_MUL && mul_done) begin
				last_avg_q <= avg_db;
			end
		end
	end

	// Datapath: shift-add multiplier, serial divider and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (new_sample) begin
					neg_q   <= dn_w[TICK_W-1];
					mag_q   <= dn_w[TICK_W-1] ? -dn_w : dn_w;
					acc_q   <= '0;
					mcand_q <= ACC_W'(dt_w);
					mult_q  <= MUL_W'(ppr_eff);
				end
			end
			ST_DEN_MUL: begin
				if (mul_done) begin
					den_q   <= acc_q[DEN_W-1:0];
					acc_q   <= '0;
					mcand_q <= ACC_W'(mag_q);
					mult_q  <= MUL_W'(RPM_FACTOR);
				end else begin
					acc_q   <= mult_q[0] ? acc_q + mcand_q : acc_q;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
				end
			end
			ST_NUM_MUL: begin
				if (mul_done) begin
					num_q <= {acc_q[PROD_W-1:0], {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= CNT_W'(NUM_W - 1);
				end else begin
					acc_q   <= mult_q[0] ? acc_q + mcand_q : acc_q;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
				end
			end
			ST_DIVIDE: begin
				rem_q <= trial_ge ? trial - {1'b0, den_q} : trial;
				num_q <= num_q << 1;
				quo_q <= {quo_q[SPEED_W-2:0], trial_ge};
				ovf_q <= ovf_q | quo_q[SPEED_W-1];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_SATURATE: begin
				inst_q  <= inst_w;
				acc_q   <= {{(ACC_W-SPEED_W-WEIGHT_SHIFT){last_avg_q[SPEED_W-1]}},
					last_avg_q, {WEIGHT_SHIFT{1'b0}}};
				mcand_q <= {{(ACC_W-SPEED_W-1){diff_w[SPEED_W]}}, diff_w};
				mult_q  <= MUL_W'(w_eff);
			end
			ST_AVG_MUL: begin
				if (mul_done) begin
					spd_q   <= avg_db;
					acc_q   <= '0;
					mcand_q <= {{(ACC_W-SPEED_W){avg_db[SPEED_W-1]}}, avg_db};
					mult_q  <= MUL_W'(RAD_COEF);
				end else begin
					acc_q   <= mult_q[0] ? acc_q + mcand_q : acc_q;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
				end
			end
			ST_RAD_MUL: begin
				if (mul_done) begin
					spd_q <= $signed(acc_q[RAD_SHIFT+SPEED_W-1:RAD_SHIFT]);
				end else begin
					acc_q   <= mult_q[0] ? acc_q + mcand_q : acc_q;
					mcand_q <= mcand_q << 1;
					mult_q  <= mult_q >> 1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					speed_q   <= spd_q;
					instant_q <= inst_q;
				end
			end
			default: ;
		endcase
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign speed       = speed_q;
	assign instant_rpm = instant_q;

endmodule

>>> tb/tb_encoder_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder speed estimator testbench
// Drives tick and millisecond stamps into the estimator and checks every
// result against a cycle-free predictor of the rpm, averaging, deadband and
// radian arithmetic. The run covers directed corner cases, several register
// settings and random encoder traffic under three patterns of flow control.
// ----------------------------------------------------------------------------
module tb_encoder_speed_estimator;
	import enc_spd_pkg::*;

	// Arithmetic of the predictor; all but the fraction width are kept independent of the design constants.
	localparam int     FRAC          = FRAC_BITS_DEF;
	localparam longint RPM_PER_TICK  = 15000;
	localparam longint RAD_PER_RPM   = 1756015;
	localparam int     RAD_Q         = 24;
	localparam longint FULL_WEIGHT   = 65536;

	// Run shape.
	localparam int SETTLE_CYCLES = 300;
	localparam int SEGMENTS      = 10;
	localparam int SEG_ITEMS     = 200;

	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic signed [SPEED_W-1:0] instant;
	} speed_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [APB_AW-1:0]          paddr = '0;
	logic [APB_DW-1:0]          pwdata = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [TICK_W-1:0]   tick_count = '0;
	logic [TIME_W-1:0]          time_ms = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SPEED_W-1:0]  speed;
	logic signed [SPEED_W-1:0]  instant_rpm;

	// Register copies and estimator state of the predictor.
	logic [DEADBAND_W-1:0] cfg_deadband = DEADBAND_RST;
	logic [WEIGHT_W-1:0]   cfg_weight = WEIGHT_RST;
	logic [PPR_W-1:0]      cfg_ppr = PPR_RST;
	logic                  cfg_radians = 1'b0;
	logic [TICK_W-1:0]     est_last_ticks = '0;
	logic [TIME_W-1:0]     est_last_time = '0;
	int                    est_last_avg = 0;

	// Last stamps sent, used to build well-formed encoder streams.
	logic [TICK_W-1:0] stream_ticks = '0;
	logic [TIME_W-1:0] stream_time = '0;

	speed_result_t expected_speeds[$];
	int            error_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	encoder_speed_estimator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.tick_count  (tick_count),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.speed       (speed),
		.instant_rpm (instant_rpm)
	);

	always #4 clk = ~clk;

	// The result side stalls at random according to the current pattern.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Computes the result of one sample and advances the estimator state.
	// Returns zero when the time stamp repeats and no result is due.
	function automatic bit predict_speed(input logic [TICK_W-1:0] ticks,
			input logic [TIME_W-1:0] now, output speed_result_t res);
		logic [31:0] dt;
		logic [31:0] dn;
		logic [63:0] mag;
		logic [63:0] den;
		logic [63:0] quot;
		logic [16:0] w;
		int          inst;
		int          avg;
		longint      sum;
		longint      abs_avg;
		longint      rad;
		dt = now - est_last_time;
		res = '0;
		if (dt == 0)
			return 1'b0;

		// Instantaneous rpm, truncated toward zero and saturated.
		dn = ticks - est_last_ticks;
		mag = dn[31] ? (64'h1_0000_0000 - {32'd0, dn}) : {32'd0, dn};
		den = {32'd0, dt} * ((cfg_ppr == 0) ? 64'd1 : {48'd0, cfg_ppr});
		quot = ((mag * RPM_PER_TICK) << FRAC) / den;
		if (dn[31])
			inst = (quot >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(quot[31:0]);
		else
			inst = (quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(quot[31:0]);

		// Exponential average with the weight clamped to 1 .. 1.0.
		if (cfg_weight == 0)
			w = 17'd1;
		else if (cfg_weight > 17'd65536)
			w = 17'd65536;
		else
			w = cfg_weight;
		sum = longint'(est_last_avg) * (FULL_WEIGHT - longint'(w))
			+ longint'(inst) * longint'(w);
		avg = int'(sum >>> 16);

		// Deadband, applied before storing.
		abs_avg = (avg < 0) ? -longint'(avg) : longint'(avg);
		if (abs_avg < longint'(cfg_deadband))
			avg = 0;

		rad = (longint'(avg) * RAD_PER_RPM) >>> RAD_Q;
		res.speed = cfg_radians ? int'(rad) : avg;
		res.instant = inst;

		est_last_ticks = ticks;
		est_last_time = now;
		est_last_avg = avg;
		return 1'b1;
	endfunction

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		speed_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_speeds.size() == 0) begin
				report_mismatch($sformatf("unexpected result speed=%0d instant_rpm=%0d",
					speed, instant_rpm));
			end else begin
				want = expected_speeds.pop_front();
				if (speed !== want.speed)
					report_mismatch($sformatf("speed got %0d expected %0d",
						speed, want.speed));
				if (instant_rpm !== want.instant)
					report_mismatch($sformatf("instant_rpm got %0d expected %0d",
						instant_rpm, want.instant));
			end
		end
	end

	// Sends one sample request, with a random gap in front of it.
	task automatic send_sample(input logic [TICK_W-1:0] tk, input logic [TIME_W-1:0] tm);
		speed_result_t res;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		tick_count <= tk;
		time_ms <= tm;
		do @(posedge clk); while (in_stall);
		stream_ticks = tk;
		stream_time = tm;
		if (predict_speed(tk, tm, res))
			expected_speeds.push_back(res);
	endtask

	// Lets the block drain so that registers can be written safely.
	task automatic wait_block_idle();
		in_valid <= 1'b0;
		while (expected_speeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: setup cycle, then access until pready.
	// psel is left high so that writes can follow back to back.
	task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEADBAND: cfg_deadband = value[DEADBAND_W-1:0];
			REG_WEIGHT:   cfg_weight = value[WEIGHT_W-1:0];
			REG_PPR:      cfg_ppr = value[PPR_W-1:0];
			REG_RADIANS:  cfg_radians = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [APB_DW-1:0] deadband,
			input logic [APB_DW-1:0] weight, input logic [APB_DW-1:0] ppr,
			input logic [APB_DW-1:0] radians);
		wait_block_idle();
		write_register(REG_DEADBAND, deadband);
		write_register(REG_WEIGHT, weight);
		write_register(REG_PPR, ppr);
		write_register(REG_RADIANS, radians);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// A stamp equal to the stored one yields nothing and keeps the state.
	task automatic test_repeat_stamp();
		send_sample(32'd77, 32'd0);
		send_sample(32'd1, 32'd1);
		send_sample(32'd500, 32'd1);
		send_sample(32'd2, 32'd2);
	endtask

	// Tick and time counters wrapping through their limits.
	task automatic test_counter_wrap();
		send_sample(32'hFFFF_FFF0, 32'd3);
		send_sample(32'h0000_0010, 32'hFFFF_FFFF);
		send_sample(32'h0000_0020, 32'd4);
	endtask

	// Largest tick steps in both directions saturate the instant rpm.
	task automatic test_saturation();
		send_sample(32'h8000_0020, 32'd5);
		send_sample(32'h0000_001F, 32'd6);
		send_sample(32'h0000_001F, 32'd7);
	endtask

	// Register extremes: full deadband, weight of zero, one and above one,
	// pulses per revolution of zero and of its maximum, both output units.
	task automatic test_register_extremes();
		configure(32'hFF_FFFF, 32'd65536, 32'd65535, 32'd1);
		for (int k = 0; k < 4; k++) begin
			case (k)
				1: configure(32'd0, 32'd0, 32'd0, 32'd1);
				2: configure(32'd0, 32'h1_FFFF, 32'd1, 32'd0);
				3: configure(32'd1000, 32'd1, 32'd7, 32'd1);
				default: ;
			endcase
			send_sample(stream_ticks + 32'd1000, stream_time + 32'd1);
			send_sample(stream_ticks - 32'd1000, stream_time + 32'd1);
			send_sample(stream_ticks + 32'd3, stream_time + 32'd2);
		end
	endtask

	// Random encoder streams: mostly steady rotation with jitter, plus
	// repeated stamps, arbitrary stamps and sudden tick jumps.
	task automatic test_random_traffic();
		int          seg_rate;
		int          pick;
		int          dticks;
		logic [31:0] dt;
		logic [31:0] deadband;
		logic [31:0] weight;
		logic [31:0] ppr;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 4) begin
				send_idle_pct = 33;
				recv_stall_pct = 85;
			end else if (seg < 7) begin
				send_idle_pct = 85;
				recv_stall_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end

			// New register setting for this segment, extremes included.
			pick = $urandom_range(9);
			deadband = (pick < 4) ? 32'd0 : (pick < 8) ? $urandom_range(0, 24'hFF_FFFF) :
				(pick == 8) ? 32'hFF_FFFF : $urandom_range(0, 4096);
			pick = $urandom_range(19);
			weight = (pick < 3) ? 32'd0 : (pick < 5) ? 32'd65536 :
				(pick < 7) ? $urandom_range(65537, 131071) : $urandom_range(1, 65535);
			pick = $urandom_range(9);
			ppr = (pick < 5) ? $urandom_range(1, 64) : (pick < 7) ? $urandom_range(0, 65535) :
				(pick == 7) ? 32'd0 : (pick == 8) ? 32'd65535 : $urandom_range(65, 4096);
			configure(deadband, weight, ppr, $urandom_range(1));

			seg_rate = int'($urandom_range(0, 400)) - 200;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 6) begin
					send_sample(stream_ticks + $urandom_range(0, 50), stream_time);
				end else if (pick < 12) begin
					send_sample($urandom(), $urandom());
				end else begin
					dt = ($urandom_range(9) != 0) ? $urandom_range(1, 20) :
						$urandom_range(1, 100000);
					dticks = seg_rate * int'(dt) + int'($urandom_range(0, 20)) - 10;
					if ($urandom_range(49) == 0)
						dticks = int'($urandom());
					send_sample(stream_ticks + dticks, stream_time + dt);
				end
			end
		end
	endtask

	initial begin
		send_idle_pct = 33;
		recv_stall_pct = 85;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_repeat_stamp();
		test_counter_wrap();
		test_saturation();
		test_register_extremes();
		test_random_traffic();

		// Drain the remaining results, bounded, then let the block settle.
		in_valid <= 1'b0;
		for (int n = 0; n < 200000 && expected_speeds.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_speeds.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				expected_speeds.size()));

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#30_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
